// ===== hdl/abdc_pkg.sv =====
package abdc_pkg;

  // field widths
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned BYTES_W   = 24;
  localparam int unsigned DROP_W    = 24;
  localparam int unsigned MAX_W     = 16;
  localparam int unsigned GRAN_W    = 16;
  localparam int unsigned IVL_W     = 16;
  localparam int unsigned RATE_W    = 18;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned FILL_W    = 32;

  // bytes to ms scale factor
  localparam int unsigned SCALE     = 1000;

  // shared divider: 34-bit dividend (24-bit bytes times 1000), 18-bit divisor
  localparam int unsigned DIV_W     = 34;
  localparam int unsigned DVS_W     = 18;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // APB register port
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_MAX_FILL    = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_GRANULARITY = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_INTERVAL    = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SAMPLE_RATE = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_CHANNELS    = IDX_W'(4);

  localparam logic [MAX_W-1:0]  MAX_FILL_RST    = MAX_W'(100);
  localparam logic [GRAN_W-1:0] GRANULARITY_RST = '0;
  localparam logic [IVL_W-1:0]  INTERVAL_RST    = IVL_W'(5000);
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = RATE_W'(8000);
  localparam logic [CHAN_W-1:0] CHANNELS_RST    = CHAN_W'(1);

  typedef struct packed {
    logic [NOW_W-1:0]   now_ms;
    logic [BYTES_W-1:0] fill_bytes;
  } item_t;

  typedef struct packed {
    logic              drop_request;
    logic [DROP_W-1:0] drop_ms;
    logic              interval_closed;
  } result_t;

  typedef struct packed {
    logic [MAX_W-1:0]  max_fill_ms;
    logic [GRAN_W-1:0] gran_ms;
    logic [IVL_W-1:0]  interval_ms;
    logic [RATE_W-1:0] sample_rate;
    logic [CHAN_W-1:0] channel_count;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/abdc_div.sv =====
module abdc_div (
  input  logic              clk,
  input  logic              rst,
  input  abdc_pkg::div_req_t req,
  output abdc_pkg::div_rsp_t rsp
);
  import abdc_pkg::*;

  // restoring divider, one quotient bit per cycle, MSB first
  logic [DIV_W-1:0]     quot;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;

  logic [DVS_W:0]       trial;
  logic                 fits;
  logic [DVS_W:0]       trial_sub;

  assign trial     = {rem, quot[DIV_W-1]};
  assign fits      = trial >= {1'b0, dvs};
  // zero divisor: every bit fits, quotient ends all ones
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= DIV_CNT_W'(DIV_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == DIV_CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (cnt != '0) begin
      quot <= {quot[DIV_W-2:0], fits};
      rem  <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

// ===== hdl/abdc_regs.sv =====
module abdc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [abdc_pkg::ADDR_W-1:0]   paddr,
  input  logic [abdc_pkg::DATA_W-1:0]   pwdata,
  output logic [abdc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output abdc_pkg::cfg_t                cfg
);
  import abdc_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_fill_ms    <= MAX_FILL_RST;
      cfg.gran_ms        <= GRANULARITY_RST;
      cfg.interval_ms    <= INTERVAL_RST;
      cfg.sample_rate    <= SAMPLE_RATE_RST;
      cfg.channel_count  <= CHANNELS_RST;
    end else if (wr) begin
      case (idx)
        REG_MAX_FILL:    cfg.max_fill_ms    <= pwdata[MAX_W-1:0];
        REG_GRANULARITY: cfg.gran_ms        <= pwdata[GRAN_W-1:0];
        REG_INTERVAL:    cfg.interval_ms    <= pwdata[IVL_W-1:0];
        REG_SAMPLE_RATE: cfg.sample_rate    <= pwdata[RATE_W-1:0];
        REG_CHANNELS:    cfg.channel_count  <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_FILL:    prdata = DATA_W'(cfg.max_fill_ms);
      REG_GRANULARITY: prdata = DATA_W'(cfg.gran_ms);
      REG_INTERVAL:    prdata = DATA_W'(cfg.interval_ms);
      REG_SAMPLE_RATE: prdata = DATA_W'(cfg.sample_rate);
      REG_CHANNELS:    prdata = DATA_W'(cfg.channel_count);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== hdl/abdc_ctrl.sv =====
module abdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  abdc_pkg::cfg_t      cfg,
  input  logic                item_valid,
  output logic                item_stall,
  input  abdc_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output abdc_pkg::result_t   result,
  output abdc_pkg::div_req_t  div_req,
  input  abdc_pkg::div_rsp_t  div_rsp
);
  import abdc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIV1 = 7'b0000100,
    S_DIV2 = 7'b0001000,
    S_MIN  = 7'b0010000,
    S_DIFF = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // interval state
  logic [NOW_W-1:0]   start_ms;
  logic [FILL_W-1:0]  min_fill;

  // per-word working registers
  logic [NOW_W-1:0]   now_r;
  logic [BYTES_W-1:0] bytes_r;
  logic               closed_r;
  logic [FILL_W-1:0]  fill_r;
  logic [FILL_W-1:0]  diff_r;
  logic               cand_r;

  logic               take_in;
  logic               out_free;
  logic [NOW_W-1:0]   elapsed;
  logic [FILL_W-1:0]  max32;
  logic [FILL_W-1:0]  max4;
  logic [FILL_W-1:0]  tol;
  logic [FILL_W-1:0]  drop_raw;
  logic               request;
  logic [DROP_W-1:0]  drop_sat;

  assign item_stall = (state != S_IDLE);
  assign take_in    = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  assign elapsed  = item.now_ms - start_ms;
  assign max32    = FILL_W'(cfg.max_fill_ms);
  assign max4     = FILL_W'({cfg.max_fill_ms, 2'b00});
  assign tol      = FILL_W'(cfg.gran_ms >> 1);
  assign request  = cand_r && (diff_r > tol);
  assign drop_raw = diff_r - tol;
  assign drop_sat = (drop_raw[FILL_W-1:DROP_W] != '0) ? '1 : drop_raw[DROP_W-1:0];

  // divider requests: scaled bytes by rate, then that quotient by channels
  always_comb begin
    div_req = '0;
    case (state)
      S_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(bytes_r) * DIV_W'(SCALE);
        div_req.divisor  = cfg.sample_rate;
      end
      S_DIV1: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DIV_W'(div_rsp.quotient[FILL_W-1:0]);
        div_req.divisor  = DVS_W'(cfg.channel_count);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (take_in) state_next = S_MUL;
      S_MUL:   state_next = S_DIV1;
      S_DIV1:  if (div_rsp.done) state_next = S_DIV2;
      S_DIV2:  if (div_rsp.done) state_next = S_MIN;
      S_MIN:   state_next = S_DIFF;
      S_DIFF:  state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      start_ms     <= '0;
      min_fill     <= '1;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take_in && start_ms == '0) begin
        start_ms <= item.now_ms;
      end
      if (state == S_MIN && (fill_r < min_fill || min_fill == '1)) begin
        min_fill <= fill_r;
      end
      if (state == S_DIFF && closed_r) begin
        start_ms <= now_r;
        min_fill <= '1;
      end
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      now_r    <= item.now_ms;
      bytes_r  <= item.fill_bytes;
      closed_r <= elapsed >= NOW_W'(cfg.interval_ms);
    end
    if (state == S_DIV2 && div_rsp.done) begin
      fill_r <= div_rsp.quotient[FILL_W-1:0];
    end
    if (state == S_DIFF) begin
      if (closed_r && min_fill != '1 && min_fill > max32) begin
        cand_r <= 1'b1;
        diff_r <= min_fill - max32;
      end else if (closed_r && fill_r > max4) begin
        cand_r <= 1'b1;
        diff_r <= (fill_r - max32) >> 1;
      end else begin
        cand_r <= 1'b0;
        diff_r <= '0;
      end
    end
    if (state == S_OUT && out_free) begin
      result.drop_request    <= request;
      result.drop_ms         <= request ? drop_sat : '0;
      result.interval_closed <= closed_r;
    end
  end

endmodule

// ===== hdl/audio_buffer_drop_controller.sv =====
// Audio buffer drop controller.
//
// Item channel (item_valid / item_stall / item): one word per buffer put,
// carrying the current time in ms and the bytes held after the put.
// Result channel (result_valid / result_stall / result): one word per put,
// with the drop request, the ms to drop and whether an interval closed.
// Registers sit on an APB-style port at byte addresses 0, 4, 8, 12, 16;
// pready is tied high, writes land on the access cycle.
//
// A word is worked on through the states S_MUL, S_DIV1, S_DIV2, S_MIN,
// S_DIFF and S_OUT, and the next word is not taken before S_OUT is left;
// the shared divider divides the scaled bytes by sample rate and then
// divides that quotient by channel count.
// item_stall is high while a word is being worked on. The result sits in an
// output register, so the next word is accepted while a result waits; a
// stalled receiver only holds the block once a second result is ready.
// Reset clears the registers to their defaults, the interval start to zero
// and the minimum fill to all ones (no sample yet).
module audio_buffer_drop_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  abdc_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output abdc_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abdc_pkg::ADDR_W-1:0] paddr,
  input  logic [abdc_pkg::DATA_W-1:0] pwdata,
  output logic [abdc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import abdc_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // configuration registers
  abdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer, interval tracking and drop decision
  abdc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .div_req      (div_req),
    .div_rsp      (div_rsp)
  );

  // one shared serial divider for both divisions
  abdc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// ===== hdl/abdc_checker.sv =====
module abdc_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input abdc_pkg::result_t result
);
  import abdc_pkg::*;

  // a word in flight keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input accepted while a word is in flight");

  a_drop_needs_close: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.drop_request |-> result.interval_closed)
    else $error("drop requested without a closed interval");

  a_drop_zero_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.drop_request |-> result.drop_ms == '0)
    else $error("drop_ms nonzero without a request");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

endmodule

bind audio_buffer_drop_controller abdc_checker u_abdc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
